/* src/assert_macros.svh */
// Assertion macros shared by the checker files of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is switched off while reset is high.
`define TESB_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent assertion that also holds across reset.
`define TESB_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* src/tesb_pkg.sv */
// Shared types, constants and helpers of the tilt equalizer.
`timescale 1ns / 1ps
`default_nettype none

package tesb_pkg;

  localparam int CH_W       = 4;
  localparam int IDX_W      = 3;
  localparam int CFG_W      = 64;
  localparam int COEF_W     = 32;
  localparam int COEF_FRAC  = 28;
  localparam int STATE_W    = 48;
  localparam int STATE_FRAC = 40;
  localparam int PROD_W     = 45;
  localparam int ACC_W      = 50;
  localparam int MEM_W      = 4 * STATE_W;

  localparam int OPS_PER_SHELF = 5;
  localparam int STEP_W        = 4;

  // Register indexes of the configuration port.
  localparam logic [IDX_W-1:0] REG_B0     = 3'd0;
  localparam logic [IDX_W-1:0] REG_B1     = 3'd1;
  localparam logic [IDX_W-1:0] REG_B2     = 3'd2;
  localparam logic [IDX_W-1:0] REG_A1     = 3'd3;
  localparam logic [IDX_W-1:0] REG_A2     = 3'd4;
  localparam logic [IDX_W-1:0] REG_ACTIVE = 3'd5;

  // Unity gain on both shelves: 1.0 in Q3.28 in each half.
  localparam logic [CFG_W-1:0] B0_RESET     = 64'h1000_0000_1000_0000;
  localparam logic [CH_W-1:0]  ACTIVE_RESET = 4'd2;

  localparam logic signed [ACC_W-1:0] ST_MAX =
    (ACC_W'(1) << (STATE_W - 1)) - ACC_W'(1);
  localparam logic signed [ACC_W-1:0] ST_MIN = ~ST_MAX;

  typedef enum logic [2:0] {
    OP_B0 = 3'd0,
    OP_B1 = 3'd1,
    OP_B2 = 3'd2,
    OP_A1 = 3'd3,
    OP_A2 = 3'd4
  } op_t;

  typedef struct packed {
    logic issue;
    logic shelf;
    op_t  op;
  } issue_t;

  typedef struct packed {
    logic [CFG_W-1:0] b0;
    logic [CFG_W-1:0] b1;
    logic [CFG_W-1:0] b2;
    logic [CFG_W-1:0] a1;
    logic [CFG_W-1:0] a2;
  } coefs_t;

  typedef struct packed {
    logic signed [STATE_W-1:0] hz2;
    logic signed [STATE_W-1:0] hz1;
    logic signed [STATE_W-1:0] lz2;
    logic signed [STATE_W-1:0] lz1;
  } state_t;

  function automatic logic signed [STATE_W-1:0] sat_state(
    input logic signed [ACC_W-1:0] v
  );
    logic signed [ACC_W-1:0] c;
    if (v > ST_MAX) begin
      c = ST_MAX;
    end else if (v < ST_MIN) begin
      c = ST_MIN;
    end else begin
      c = v;
    end
    return c[STATE_W-1:0];
  endfunction

endpackage

`default_nettype wire

/* src/tesb_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module tesb_ram #(
  parameter int WIDTH = 192,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* src/tesb_cfg.sv */
// Configuration register file: coefficient pairs and active channel count.
`timescale 1ns / 1ps
`default_nettype none

module tesb_cfg (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         wr_en,
  input  wire logic [tesb_pkg::IDX_W-1:0]   wr_index,
  input  wire logic [tesb_pkg::CFG_W-1:0]   wr_data,
  output tesb_pkg::coefs_t                  coefs,
  output logic      [tesb_pkg::CH_W-1:0]    active
);
  import tesb_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      coefs.b0 <= B0_RESET;
      coefs.b1 <= '0;
      coefs.b2 <= '0;
      coefs.a1 <= '0;
      coefs.a2 <= '0;
      active   <= ACTIVE_RESET;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_B0:     coefs.b0 <= wr_data;
        REG_B1:     coefs.b1 <= wr_data;
        REG_B2:     coefs.b2 <= wr_data;
        REG_A1:     coefs.a1 <= wr_data;
        REG_A2:     coefs.a2 <= wr_data;
        REG_ACTIVE: active   <= wr_data[CH_W-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

/* src/tesb_dp.sv */
// Shared multiplier and accumulate/saturate datapath for both shelves.
`timescale 1ns / 1ps
`default_nettype none

module tesb_dp #(
  parameter int SAMPLE_BITS = 24
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  tesb_pkg::issue_t                   ctl,
  input  tesb_pkg::coefs_t                   coefs,
  input  wire logic signed [SAMPLE_BITS-1:0] x_in,
  input  tesb_pkg::state_t                   st_old,
  output logic signed      [SAMPLE_BITS-1:0] y_lo,
  output logic signed      [SAMPLE_BITS-1:0] y_hi,
  output tesb_pkg::state_t                   st_new
);
  import tesb_pkg::*;

  localparam int SHIFT  = SAMPLE_BITS - 1 + COEF_FRAC - STATE_FRAC;
  localparam int OSH    = STATE_FRAC - (SAMPLE_BITS - 1);
  localparam int FULL_W = COEF_W + SAMPLE_BITS;
  localparam logic signed [ACC_W-1:0] RND  = ACC_W'(1) << (OSH - 1);
  localparam logic signed [ACC_W-1:0] SMAX =
    (ACC_W'(1) << (SAMPLE_BITS - 1)) - ACC_W'(1);
  localparam logic signed [ACC_W-1:0] SMIN = ~SMAX;

  // Issue side: pick coefficient half and operand, multiply, floor to Q.40.
  logic [CFG_W-1:0]               coef_word;
  logic signed [COEF_W-1:0]       coef;
  logic signed [SAMPLE_BITS-1:0]  x_sh;
  logic signed [SAMPLE_BITS-1:0]  y_sh;
  logic signed [SAMPLE_BITS-1:0]  opnd;
  logic signed [FULL_W-1:0]       full;
  logic signed [FULL_W-1:0]       full_sh;

  always_comb begin
    unique case (ctl.op)
      OP_B0:   coef_word = coefs.b0;
      OP_B1:   coef_word = coefs.b1;
      OP_B2:   coef_word = coefs.b2;
      OP_A1:   coef_word = coefs.a1;
      OP_A2:   coef_word = coefs.a2;
      default: coef_word = coefs.b0;
    endcase
  end

  assign coef    = ctl.shelf ? coef_word[2*COEF_W-1:COEF_W] : coef_word[COEF_W-1:0];
  // The high shelf filters the saturated low shelf output.
  assign x_sh    = ctl.shelf ? y_lo : x_in;
  assign y_sh    = ctl.shelf ? y_hi : y_lo;
  assign opnd    = (ctl.op == OP_A1 || ctl.op == OP_A2) ? y_sh : x_sh;
  assign full    = coef * opnd;
  assign full_sh = full >>> SHIFT;

  logic signed [PROD_W-1:0] prod;
  issue_t                   ret;

  always_ff @(posedge clk) begin
    if (rst) begin
      ret <= '0;
    end else begin
      ret <= ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.issue) begin
      prod <= full_sh[PROD_W-1:0];
    end
  end

  // Retire side: one product a cycle folds into the shelf equations.
  logic signed [STATE_W-1:0] z1_old;
  logic signed [STATE_W-1:0] z2_old;
  logic signed [ACC_W-1:0]   prod_e;
  logic signed [ACC_W-1:0]   z1_e;
  logic signed [ACC_W-1:0]   z2_e;
  logic signed [ACC_W-1:0]   acc_y;
  logic signed [ACC_W-1:0]   y_full;
  logic signed [ACC_W-1:0]   y_clamp;
  logic signed [ACC_W-1:0]   t1;
  logic signed [ACC_W-1:0]   t2;
  logic signed [ACC_W-1:0]   z1_sum;
  logic signed [ACC_W-1:0]   z2_sum;

  assign z1_old = ret.shelf ? st_old.hz1 : st_old.lz1;
  assign z2_old = ret.shelf ? st_old.hz2 : st_old.lz2;
  assign prod_e = {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};
  assign z1_e   = {{(ACC_W-STATE_W){z1_old[STATE_W-1]}}, z1_old};
  assign z2_e   = {{(ACC_W-STATE_W){z2_old[STATE_W-1]}}, z2_old};
  assign acc_y  = prod_e + z1_e + RND;
  assign y_full = acc_y >>> OSH;
  assign z1_sum = t1 - prod_e;
  assign z2_sum = t2 - prod_e;

  always_comb begin
    if (y_full > SMAX) begin
      y_clamp = SMAX;
    end else if (y_full < SMIN) begin
      y_clamp = SMIN;
    end else begin
      y_clamp = y_full;
    end
  end

  always_ff @(posedge clk) begin
    if (ret.issue) begin
      unique case (ret.op)
        OP_B0: begin
          if (ret.shelf) begin
            y_hi <= y_clamp[SAMPLE_BITS-1:0];
          end else begin
            y_lo <= y_clamp[SAMPLE_BITS-1:0];
          end
        end
        OP_B1: t1 <= prod_e + z2_e;
        OP_B2: t2 <= prod_e;
        OP_A1: begin
          if (ret.shelf) begin
            st_new.hz1 <= sat_state(z1_sum);
          end else begin
            st_new.lz1 <= sat_state(z1_sum);
          end
        end
        OP_A2: begin
          if (ret.shelf) begin
            st_new.hz2 <= sat_state(z2_sum);
          end else begin
            st_new.lz2 <= sat_state(z2_sum);
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

/* src/tilt_eq_dual_shelf_biquad.sv */
// Active channel: the ten products of the two shelves go through one shared multiplier,
// plus the state read and write-back in the channel state RAM; the input stays closed
// until the result beat is loaded into the output register, so one item is in work at a time.
// Inactive channel: passes the sample through unfiltered, also one item at a time.
// Synchronous reset restores the coefficient and count registers and clears all
// channel state at once through per-channel valid bits; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module tilt_eq_dual_shelf_biquad #(
  parameter int CHANNELS    = 8,
  parameter int SAMPLE_BITS = 24,
  localparam int DATA_W = ((tesb_pkg::CH_W + SAMPLE_BITS + 7) / 8) * 8
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         s_tvalid,
  output logic                              s_tready,
  input  wire logic [DATA_W-1:0]            s_tdata,   // channel, sample_in
  output logic                              m_tvalid,
  input  wire logic                         m_tready,
  output logic      [DATA_W-1:0]            m_tdata,   // channel_out, sample_out
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [tesb_pkg::IDX_W-1:0]   cfg_index,
  input  wire logic [tesb_pkg::CFG_W-1:0]   cfg_data
);
  import tesb_pkg::*;

  localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [STEP_W-1:0] SHELF_STEP = STEP_W'(OPS_PER_SHELF);
  localparam logic [STEP_W-1:0] CALC_LAST  = STEP_W'(2 * OPS_PER_SHELF);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_CALC  = 4'b0010,
    S_WRITE = 4'b0100,
    S_DONE  = 4'b1000
  } fsm_t;

  fsm_t state;

  // Configuration registers.
  coefs_t          coefs;
  logic [CH_W-1:0] active;

  assign cfg_ready = 1'b1;

  tesb_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid & cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .coefs    (coefs),
    .active   (active)
  );

  // Input unpacking and channel decode.
  logic [CH_W-1:0]               ch_in;
  logic signed [SAMPLE_BITS-1:0] x_in;
  logic [AW+CH_W-1:0]            ch_wide;
  logic [AW-1:0]                 addr_in;
  logic                          in_active;
  logic                          accept;

  assign ch_in     = s_tdata[CH_W-1:0];
  assign x_in      = s_tdata[CH_W+SAMPLE_BITS-1:CH_W];
  assign ch_wide   = {{AW{1'b0}}, ch_in};
  assign addr_in   = ch_wide[AW-1:0];
  assign in_active = (ch_in < active) && (32'(ch_in) < CHANNELS);
  assign s_tready  = (state == S_IDLE);
  assign accept    = s_tvalid & s_tready;

  logic [CH_W-1:0]               ch_q;
  logic signed [SAMPLE_BITS-1:0] x_q;
  logic [AW-1:0]                 addr_q;
  logic                          active_q;
  logic                          vld_q;
  logic [CHANNELS-1:0]           valid;
  logic [STEP_W-1:0]             cnt;

  always_ff @(posedge clk) begin
    if (accept) begin
      ch_q     <= ch_in;
      x_q      <= x_in;
      addr_q   <= addr_in;
      active_q <= in_active;
      vld_q    <= in_active & valid[addr_in];
    end
  end

  // Channel state memory: all four delay registers of a channel in one word.
  logic [MEM_W-1:0] ram_rdata;
  state_t           st_old;
  state_t           st_new;
  logic             ram_we;

  assign ram_we = (state == S_WRITE);

  tesb_ram #(
    .WIDTH (MEM_W),
    .DEPTH (CHANNELS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (addr_q),
    .wdata (st_new),
    .re    (accept),
    .raddr (addr_in),
    .rdata (ram_rdata)
  );

  // A channel never written since reset reads as zero state.
  assign st_old = vld_q ? state_t'(ram_rdata) : '0;

  // Step sequencer for the shared multiplier.
  issue_t            ctl;
  logic              shelf;
  logic [STEP_W-1:0] op_step;

  assign shelf     = (cnt >= SHELF_STEP);
  assign op_step   = shelf ? (cnt - SHELF_STEP) : cnt;
  assign ctl.issue = (state == S_CALC) && (cnt < CALC_LAST);
  assign ctl.shelf = shelf;
  assign ctl.op    = op_t'(op_step[2:0]);

  logic signed [SAMPLE_BITS-1:0] y_lo;
  logic signed [SAMPLE_BITS-1:0] y_hi;

  tesb_dp #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk    (clk),
    .rst    (rst),
    .ctl    (ctl),
    .coefs  (coefs),
    .x_in   (x_q),
    .st_old (st_old),
    .y_lo   (y_lo),
    .y_hi   (y_hi),
    .st_new (st_new)
  );

  // Output register.
  logic                          out_load;
  logic [CH_W-1:0]               out_ch;
  logic signed [SAMPLE_BITS-1:0] out_sample;

  assign out_load = (state == S_DONE) && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      cnt      <= '0;
      valid    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            cnt   <= '0;
            state <= in_active ? S_CALC : S_DONE;
          end
        end
        S_CALC: begin
          cnt <= cnt + STEP_W'(1);
          if (cnt == CALC_LAST) begin
            state <= S_WRITE;
          end
        end
        S_WRITE: begin
          valid[addr_q] <= 1'b1;
          state         <= S_DONE;
        end
        S_DONE: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase

      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_ch     <= ch_q;
      out_sample <= active_q ? y_hi : x_q;
    end
  end

  assign m_tdata = {{(DATA_W-CH_W-SAMPLE_BITS){1'b0}}, out_sample, out_ch};

endmodule

`default_nettype wire

/* src/tesb_checker.sv */
// Port-level checker for the tilt equalizer, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module tesb_checker #(
  parameter int DATA_W = 32
) (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              s_tvalid,
  input wire logic              s_tready,
  input wire logic              m_tvalid,
  input wire logic              m_tready,
  input wire logic [DATA_W-1:0] m_tdata
);

  // Reset leaves no result pending and the input side open.
  `TESB_ASSERT_ALWAYS(a_reset_state, clk, rst |=> (!m_tvalid && s_tready), "bad state after reset")

  // A stalled output beat keeps its payload.
  `TESB_ASSERT(a_out_hold, clk, rst, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)), "output beat changed while stalled")

  // One item at a time: the input closes right after a beat is taken.
  `TESB_ASSERT(a_one_item, clk, rst, (s_tvalid && s_tready) |=> !s_tready, "input open while an item is in work")

  // A new result appears only out of the finishing step, when the input is closed.
  `TESB_ASSERT(a_result_source, clk, rst, $rose(m_tvalid) |-> !$past(s_tready), "result appeared while idle")

endmodule

bind tilt_eq_dual_shelf_biquad tesb_checker #(
  .DATA_W (DATA_W)
) u_tesb_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire
